// ===== src/hcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex color string parser package
// Shared types and constants for the token tracker and the color expander.
// ----------------------------------------------------------------------------
package hcsp_pkg;

   localparam int unsigned AccWidth   = 32;
   localparam int unsigned CountWidth = 4;

   localparam logic [CountWidth-1:0] CountSat = 4'd9;
   localparam logic [CountWidth-1:0] LenRgb   = 4'd3;
   localparam logic [CountWidth-1:0] LenRgba  = 4'd4;
   localparam logic [CountWidth-1:0] LenRrggbb   = 4'd6;
   localparam logic [CountWidth-1:0] LenRrggbbaa = 4'd8;

   localparam logic [7:0] AlphaOpaque = 8'hff;

   localparam logic StatusOk         = 1'b0;
   localparam logic StatusBadLength  = 1'b1;

   // Accumulated digits and digit count at the character that ends a token.
   typedef struct packed {
      logic [AccWidth-1:0]   acc;
      logic [CountWidth-1:0] count;
   } hcsp_term_type;

endpackage

// ===== src/hcsp_token.sv =====
// ----------------------------------------------------------------------------
// Hex color token tracker
// Registers each incoming character, decodes hex digits, shifts them into the
// digit accumulator and reports the token when a non-hex character ends it.
// ----------------------------------------------------------------------------
module hcsp_token (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   input  logic                  out_ready,
   output logic                  term_push,
   output hcsp_pkg::hcsp_term_type term
);
   import hcsp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            char_ff;
   logic                  first_ff;
   logic [AccWidth-1:0]   acc_ff, acc_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  fin_ff, fin_in;

   logic                  hex_ok;
   logic [3:0]            nib;
   logic [AccWidth-1:0]   acc_eff;
   logic [CountWidth-1:0] cnt_eff;
   logic                  fin_eff;
   logic                  term_hit;
   logic                  advance;
   logic                  req_xfer;

   always_comb begin
      hex_ok = 1'b1;
      nib    = '0;
      case (char_ff) inside
         [8'h30:8'h39]: nib = 4'(char_ff - 8'h30);
         [8'h41:8'h46]: nib = 4'(char_ff - 8'h37);
         [8'h61:8'h66]: nib = 4'(char_ff - 8'h57);
         default:       hex_ok = 1'b0;
      endcase
   end

   assign acc_eff = first_ff ? '0 : acc_ff;
   assign cnt_eff = first_ff ? '0 : cnt_ff;
   assign fin_eff = first_ff ? 1'b0 : fin_ff;

   assign term_hit   = in_valid_ff && !fin_eff && !hex_ok;
   assign advance    = in_valid_ff && (!term_hit || out_ready);
   assign term_push  = term_hit && out_ready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign term.acc   = acc_eff;
   assign term.count = cnt_eff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      if (advance && !fin_eff) begin
         if (hex_ok) begin
            acc_in = {acc_eff[AccWidth-5:0], nib};
            cnt_in = (cnt_eff < CountSat) ? cnt_eff + 4'd1 : cnt_eff;
            fin_in = 1'b0;
         end else begin
            acc_in = acc_eff;
            cnt_in = cnt_eff;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         fin_ff      <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         fin_ff      <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         char_ff  <= req_tdata;
         first_ff <= req_tuser;
      end
   end

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountSat)
      else $error("digit count exceeded its saturation value");

   a_term_closes_token: assert property (@(posedge clock) disable iff (reset)
      term_push |=> fin_ff)
      else $error("token not closed after its terminator transfer");

endmodule

// ===== src/hcsp_expand.sv =====
// ----------------------------------------------------------------------------
// Hex color expander
// Turns a finished token into an RGBA8888 color and a status, and holds the
// result in the output register until the result transfer completes.
// ----------------------------------------------------------------------------
module hcsp_expand (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  term_push,
   input  hcsp_pkg::hcsp_term_type term,
   output logic                  out_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   output logic                  rsp_tuser
);
   import hcsp_pkg::*;

   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           color_ff, color_in;
   logic                  status_ff, status_in;
   logic [CountWidth-1:0] count_ff;
   logic [AccWidth-1:0]   a;

   assign a = term.acc;

   always_comb begin
      status_in = StatusOk;
      color_in  = '0;
      case (term.count)
         LenRgb: color_in = {a[11:8], a[11:8], a[7:4], a[7:4], a[3:0], a[3:0],
                             AlphaOpaque};
         LenRgba: color_in = {a[15:12], a[15:12], a[11:8], a[11:8],
                              a[7:4], a[7:4], a[3:0], a[3:0]};
         LenRrggbb: color_in = {a[23:0], AlphaOpaque};
         LenRrggbbaa: color_in = a;
         default: status_in = StatusBadLength;
      endcase
   end

   assign out_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (term_push) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (term_push) begin
         color_ff  <= color_in;
         status_ff <= status_in;
         count_ff  <= term.count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, count_ff, color_ff};
   assign rsp_tuser  = status_ff;

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff == StatusOk |->
         count_ff == LenRgb || count_ff == LenRgba ||
         count_ff == LenRrggbb || count_ff == LenRrggbbaa)
      else $error("status ok reported for an invalid digit count");

   a_bad_color_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff == StatusBadLength |-> color_ff == '0)
      else $error("nonzero color reported with invalid length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !term_push)
      else $error("pending result overwritten");

endmodule

// ===== src/hex_color_string_parser.sv =====
// ----------------------------------------------------------------------------
// Hex color string parser
// Parses CSS style hex color strings, one character per transfer, into
// RGBA8888 colors.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle and gives one result for each
// string that a non-hex character ends, from the terminator held in the input
// register. Each character passes through an input register, the digit decode
// and accumulate logic, and the result register, so a string of any length
// streams at full rate. The only stall comes from the result side: while a
// result waits in the output register and the next terminator is ready,
// req_tready is low until rsp_tready takes the waiting result.
module hex_color_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] character
   input  logic        req_tuser,  // [0] first_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] color, [35:32] digits_consumed, rest zero
   output logic        rsp_tuser   // [0] status
);
   import hcsp_pkg::*;

   logic          term_push;
   logic          out_ready;
   hcsp_term_type term;

   hcsp_token u_token (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_ready  (out_ready),
      .term_push  (term_push),
      .term       (term)
   );

   hcsp_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .term_push  (term_push),
      .term       (term),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/tb_hex_color_string_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex color string parser testbench
// Streams color strings one character per transfer into the parser, predicts
// each RGBA8888 result from its own digit tracker and checks every result
// transfer field by field. Both sides idle at random, the receiver once holds
// off for a long stretch, and the sender twice waits until all results are in.
// ----------------------------------------------------------------------------
module tb_hex_color_string_parser;
   import hcsp_pkg::*;

   localparam int unsigned LongHold   = 400;
   localparam int unsigned StallLimit = 4000;
   localparam int unsigned TargetChars = 2000;

   typedef enum logic [1:0] {
      StepChar,
      StepDrain,
      StepRxHold
   } step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [7:0]    ch;
      logic          first;
   } char_step_type;

   typedef struct packed {
      logic [31:0]           color;
      logic                  status;
      logic [CountWidth-1:0] digits;
   } parsed_color_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] character
   logic        req_tuser = 1'b0;   // [0] first_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] color, [35:32] digits_consumed
   logic        rsp_tuser;          // [0] status

   char_step_type    char_q[$];
   parsed_color_type color_q[$];

   logic [AccWidth-1:0]   digit_acc = '0;
   logic [CountWidth-1:0] digit_n = '0;
   logic                  token_done = 1'b1;

   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;
   logic        drain_wait = 1'b0;
   int unsigned tx_gap = 0;
   int unsigned rx_wait = 0;
   int unsigned rx_hold_left = 0;
   int unsigned hold_req = 0;
   int unsigned hold_ack = 0;
   int unsigned cyc = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;

   hex_color_string_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Bit 4 flags a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, 4'(c - "0")};
      end
      if (c >= "A" && c <= "F") begin
         return {1'b1, 4'(c - "A" + 8'd10)};
      end
      if (c >= "a" && c <= "f") begin
         return {1'b1, 4'(c - "a" + 8'd10)};
      end
      return 5'd0;
   endfunction

   function automatic int unsigned draw_gap(input logic quiet);
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] rand_digit();
      int unsigned v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'("0" + v);
      end
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_digit();
      logic [7:0] c;
      logic [4:0] h;
      do begin
         c = 8'($urandom_range(0, 255));
         h = hex_nibble(c);
      end while (h[4]);
      return c;
   endfunction

   task automatic queue_char(input logic [7:0] c, input logic f);
      char_q.push_back('{kind: StepChar, ch: c, first: f});
   endtask

   task automatic queue_token(input string digits, input logic [7:0] term);
      for (int i = 0; i < digits.len(); i++) begin
         queue_char(digits[i], i == 0);
      end
      queue_char(term, digits.len() == 0);
   endtask

   task automatic parse_char(input logic [7:0] ch, input logic first,
                             output logic emits, output parsed_color_type res);
      logic [4:0]  h;
      logic [31:0] spread;
      emits = 1'b0;
      res = '0;
      if (first) begin
         digit_acc = '0;
         digit_n = '0;
         token_done = 1'b0;
      end
      if (!token_done) begin
         h = hex_nibble(ch);
         if (h[4]) begin
            digit_acc = {digit_acc[AccWidth-5:0], h[3:0]};
            if (digit_n != CountSat) begin
               digit_n = digit_n + 1'b1;
            end
         end else begin
            spread = {{2{digit_acc[15:12]}}, {2{digit_acc[11:8]}},
                      {2{digit_acc[7:4]}}, {2{digit_acc[3:0]}}};
            res.status = StatusOk;
            case (digit_n)
               LenRgb: begin
                  res.color = {spread[23:0], AlphaOpaque};
               end
               LenRgba: begin
                  res.color = spread;
               end
               LenRrggbb: begin
                  res.color = {digit_acc[23:0], AlphaOpaque};
               end
               LenRrggbbaa: begin
                  res.color = digit_acc;
               end
               default: begin
                  res.color = '0;
                  res.status = StatusBadLength;
               end
            endcase
            res.digits = digit_n;
            token_done = 1'b1;
            emits = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, seen);
      end
   endtask

   always @(posedge clock) begin : track
      logic             emits;
      parsed_color_type want;
      cyc <= cyc + 1;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         digit_acc = '0;
         digit_n = '0;
         token_done = 1'b1;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata, req_tuser, emits, want);
            if (emits) begin
               color_q.push_back(want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (color_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected, got color %h status %b digits %0d",
                        $time, rsp_tdata[31:0], rsp_tuser, rsp_tdata[35:32]);
            end else begin
               want = color_q.pop_front();
               check_field("color", want.color, rsp_tdata[31:0]);
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("digits_consumed", 32'(want.digits), 32'(rsp_tdata[35:32]));
            end
         end
      end
   end

   always @(negedge clock) begin : char_driver
      char_step_type step;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (drain_wait) begin
            req_tvalid <= 1'b0;
            if (color_q.size() == 0) begin
               drain_wait <= 1'b0;
            end
         end else if (tx_gap != 0) begin
            req_tvalid <= 1'b0;
            tx_gap <= tx_gap - 1;
         end else if (char_q.size() != 0) begin
            step = char_q.pop_front();
            case (step.kind)
               StepChar: begin
                  req_tdata <= step.ch;
                  req_tuser <= step.first;
                  req_tvalid <= 1'b1;
                  tx_gap <= draw_gap((cyc % 1000) >= 700);
               end
               StepDrain: begin
                  req_tvalid <= 1'b0;
                  drain_wait <= 1'b1;
               end
               default: begin
                  req_tvalid <= 1'b0;
                  hold_req <= hold_req + 1;
               end
            endcase
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            rx_hold_left <= LongHold;
            rsp_tready <= 1'b0;
         end else if (rsp_fire || !rsp_tready) begin
            if (rx_wait != 0) begin
               rx_wait <= rx_wait - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               rx_wait <= draw_gap((cyc % 1400) < 300);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned counted;
      int unsigned strings;
      int unsigned len;
      int unsigned brk;
      int unsigned restart_at;
      int unsigned r;

      // Directed strings: ignored input before any start, the three and four digit
      // length classes, a leading space and a 0x prefix, a sign, a restart in the middle
      // of a token, trailing input after the terminator and a saturating count.
      queue_char(8'hff, 1'b0);
      queue_token("Fa0", 8'h00);
      queue_token("", " ");
      queue_token("0", "x");
      queue_char("7", 1'b0);
      queue_token("9B4e", "+");
      queue_char("c", 1'b1);
      queue_token("0123456789", "g");

      counted = 0;
      strings = 0;
      while (counted < TargetChars) begin
         strings++;
         if (strings == 40) begin
            char_q.push_back('{kind: StepRxHold, ch: 8'h00, first: 1'b0});
         end
         if (strings == 120 || strings == 200) begin
            char_q.push_back('{kind: StepDrain, ch: 8'h00, first: 1'b0});
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            case ($urandom_range(0, 3))
               0: len = LenRgb;
               1: len = LenRgba;
               2: len = LenRrggbb;
               default: len = LenRrggbbaa;
            endcase
         end else if (r < 92) begin
            len = $urandom_range(0, 12);
         end else begin
            len = $urandom_range(13, 20);
         end
         brk = $urandom_range(0, 19);
         restart_at = $urandom_range(1, len + 1);
         for (int i = 0; i < len; i++) begin
            queue_char(rand_digit(), (i == 0 && brk != 0) || (brk == 2 && i == restart_at));
         end
         if (brk != 1) begin
            queue_char(rand_non_digit(), len == 0 && brk != 0);
         end
         repeat ($urandom_range(0, 2)) begin
            queue_char(8'($urandom_range(0, 255)), 1'b0);
         end
         counted += len + 1;
      end

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_tvalid || drain_wait || color_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (color_q.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected results never arrived", $time, color_q.size());
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
